>>> hdl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// types, microcode step addresses and the control store of the heap sorter
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int UPC_BITS = 4;
  typedef logic [UPC_BITS-1:0] upc_t;

  localparam upc_t U_LOAD  = 4'd0;
  localparam upc_t U_BINIT = 4'd1;
  localparam upc_t U_BTEST = 4'd2;
  localparam upc_t U_BRD   = 4'd3;
  localparam upc_t U_BLD   = 4'd4;
  localparam upc_t U_SRD   = 4'd5;
  localparam upc_t U_SCMP  = 4'd6;
  localparam upc_t U_SINIT = 4'd7;
  localparam upc_t U_STEST = 4'd8;
  localparam upc_t U_SRD2  = 4'd9;
  localparam upc_t U_SSWAP = 4'd10;
  localparam upc_t U_OINIT = 4'd11;
  localparam upc_t U_ORD   = 4'd12;
  localparam upc_t U_OEMIT = 4'd13;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_BINIT,
    OP_BRD,
    OP_BLD,
    OP_SRD,
    OP_SCMP,
    OP_SINIT,
    OP_SRD2,
    OP_SSWAP,
    OP_OINIT,
    OP_ORD,
    OP_OEMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_CALL,
    C_WAIT_LAST,
    C_IF_I_ZERO,
    C_IF_I_LE1,
    C_SIFT,
    C_EMIT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
    upc_t  alt;
  } ctrl_t;

  typedef struct packed {
    logic accept_last;
    logic i_zero;
    logic i_le1;
    logic sift_done;
    logic out_free;
    logic final_key;
  } stat_t;

  function automatic ctrl_t ucode(input upc_t a);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_JUMP, target: U_LOAD, alt: U_LOAD};
    unique case (a)
      U_LOAD:  w = '{op: OP_LOAD,  cond: C_WAIT_LAST, target: U_LOAD,  alt: U_LOAD};
      U_BINIT: w = '{op: OP_BINIT, cond: C_NEXT,      target: U_LOAD,  alt: U_LOAD};
      U_BTEST: w = '{op: OP_NOP,   cond: C_IF_I_ZERO, target: U_SINIT, alt: U_LOAD};
      U_BRD:   w = '{op: OP_BRD,   cond: C_NEXT,      target: U_LOAD,  alt: U_LOAD};
      U_BLD:   w = '{op: OP_BLD,   cond: C_CALL,      target: U_SRD,   alt: U_BTEST};
      U_SRD:   w = '{op: OP_SRD,   cond: C_NEXT,      target: U_LOAD,  alt: U_LOAD};
      U_SCMP:  w = '{op: OP_SCMP,  cond: C_SIFT,      target: U_SRD,   alt: U_LOAD};
      U_SINIT: w = '{op: OP_SINIT, cond: C_NEXT,      target: U_LOAD,  alt: U_LOAD};
      U_STEST: w = '{op: OP_NOP,   cond: C_IF_I_LE1,  target: U_OINIT, alt: U_LOAD};
      U_SRD2:  w = '{op: OP_SRD2,  cond: C_NEXT,      target: U_LOAD,  alt: U_LOAD};
      U_SSWAP: w = '{op: OP_SSWAP, cond: C_CALL,      target: U_SRD,   alt: U_STEST};
      U_OINIT: w = '{op: OP_OINIT, cond: C_NEXT,      target: U_LOAD,  alt: U_LOAD};
      U_ORD:   w = '{op: OP_ORD,   cond: C_NEXT,      target: U_LOAD,  alt: U_LOAD};
      U_OEMIT: w = '{op: OP_OEMIT, cond: C_EMIT,      target: U_LOAD,  alt: U_ORD};
      default: w = '{op: OP_NOP,   cond: C_JUMP,      target: U_LOAD,  alt: U_LOAD};
    endcase
    return w;
  endfunction

endpackage

>>> hdl/heap_sort_engine.sv
// ----------------------------------------------------------------------------
// heap_sort_engine
// collects a set of keys and returns them in ascending order by heapsort
// ----------------------------------------------------------------------------
// keys enter on the key channel (key_valid/key_ready), one per cycle while
// the block is loading; last_key closes the set. keys past CAPACITY are
// dropped and reported through overflowed on every result of that set.
// after the closing key the control program builds a max-heap in the key
// memory and sorts it in place. each sift level is a paired child read
// from the two-port memory, then a compare and write back.
// results leave on the sort channel (sort_valid/sort_ready), lowest key
// first, each read from the key memory and then emitted; the last one
// carries end_of_run, min_value and max_value. a stalled receiver holds
// the result register and the program waits on the emit step.
// key_ready is low from the closing key until the last result is loaded.
// reset returns the program to loading with an empty set; the memory
// needs no clearing since only keys of the current set are read.
// ----------------------------------------------------------------------------
module heap_sort_engine #(
  parameter int CAPACITY = 32,
  parameter int KEY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        key_valid,
  output logic        key_ready,
  input  logic [15:0] key_value,
  input  logic        last_key,
  output logic        sort_valid,
  input  logic        sort_ready,
  output logic [15:0] sorted_value,
  output logic [4:0]  rank,
  output logic        end_of_run,
  output logic [15:0] min_value,
  output logic [15:0] max_value,
  output logic        overflowed
);
  import hse_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  hse_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  hse_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .key_valid    (key_valid),
    .key_ready    (key_ready),
    .key_value    (key_value),
    .last_key     (last_key),
    .sort_valid   (sort_valid),
    .sort_ready   (sort_ready),
    .sorted_value (sorted_value),
    .rank         (rank),
    .end_of_run   (end_of_run),
    .min_value    (min_value),
    .max_value    (max_value),
    .overflowed   (overflowed)
  );

endmodule

>>> hdl/hse_sequencer.sv
// ----------------------------------------------------------------------------
// hse_sequencer
// step counter, return register and control store lookup with branching
// ----------------------------------------------------------------------------
module hse_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  hse_pkg::stat_t stat,
  output hse_pkg::ctrl_t ctrl
);
  import hse_pkg::*;

  upc_t upc;
  upc_t upc_next;
  upc_t ret;
  upc_t ret_next;
  upc_t upc_inc;

  assign ctrl    = ucode(upc);
  assign upc_inc = upc + upc_t'(1);

  always_comb begin
    upc_next = upc_inc;
    ret_next = ret;
    unique case (ctrl.cond)
      C_NEXT:      upc_next = upc_inc;
      C_JUMP:      upc_next = ctrl.target;
      C_CALL: begin
        upc_next = ctrl.target;
        ret_next = ctrl.alt;
      end
      C_WAIT_LAST: upc_next = stat.accept_last ? upc_inc : upc;
      C_IF_I_ZERO: upc_next = stat.i_zero ? ctrl.target : upc_inc;
      C_IF_I_LE1:  upc_next = stat.i_le1 ? ctrl.target : upc_inc;
      C_SIFT:      upc_next = stat.sift_done ? ret : ctrl.target;
      C_EMIT: begin
        priority if (!stat.out_free) begin
          upc_next = upc;
        end else if (stat.final_key) begin
          upc_next = ctrl.target;
        end else begin
          upc_next = ctrl.alt;
        end
      end
      default:     upc_next = U_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_LOAD;
      ret <= U_LOAD;
    end else begin
      upc <= upc_next;
      ret <= ret_next;
    end
  end

endmodule

>>> hdl/hse_datapath.sv
// ----------------------------------------------------------------------------
// hse_datapath
// key memory, heap index registers, sift compare and result register
// ----------------------------------------------------------------------------
module hse_datapath #(
  parameter int CAPACITY = 32,
  parameter int KEY_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  hse_pkg::ctrl_t ctrl,
  output hse_pkg::stat_t stat,
  input  logic           key_valid,
  output logic           key_ready,
  input  logic [15:0]    key_value,
  input  logic           last_key,
  output logic           sort_valid,
  input  logic           sort_ready,
  output logic [15:0]    sorted_value,
  output logic [4:0]     rank,
  output logic           end_of_run,
  output logic [15:0]    min_value,
  output logic [15:0]    max_value,
  output logic           overflowed
);
  import hse_pkg::*;

  localparam int KW    = (KEY_BITS < 16) ? KEY_BITS : 16;
  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int DEPTH = 2 ** AW;

  logic [KW-1:0] mem [DEPTH];
  logic [KW-1:0] rd_a;
  logic [KW-1:0] rd_b;

  logic          we;
  logic [AW-1:0] waddr;
  logic [KW-1:0] wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;

  logic [CW-1:0] cnt;
  logic          ovf;
  logic [CW-1:0] i;
  logic [CW-1:0] lim;
  logic [AW-1:0] node;
  logic [AW-1:0] k;
  logic [KW-1:0] vn;
  logic [KW-1:0] minr;

  logic          accept;
  logic          room;
  logic [CW-1:0] i_dec;
  logic [AW+1:0] lc;
  logic [AW+1:0] rc;
  logic [AW+1:0] lim_x;
  logic          l_ok;
  logic          r_ok;
  logic [KW-1:0] bigv;
  logic [AW+1:0] big;
  logic          done;
  logic          free;
  logic          final_key;

  assign key_ready = (ctrl.op == OP_LOAD);
  assign accept    = key_valid && key_ready;
  assign room      = cnt < CW'(CAPACITY);
  assign i_dec     = i - CW'(1);

  // sift compare: children of the hole against the traveling key
  assign lc    = {1'b0, node, 1'b1};
  assign rc    = lc + (AW+2)'(1);
  assign lim_x = (AW+2)'(lim);
  assign l_ok  = (lc < lim_x) && (rd_a > vn);
  assign bigv  = l_ok ? rd_a : vn;
  assign r_ok  = (rc < lim_x) && (rd_b > bigv);
  assign big   = r_ok ? rc : (l_ok ? lc : (AW+2)'(node));
  assign done  = !l_ok && !r_ok;

  assign free      = !sort_valid || sort_ready;
  assign final_key = (CW'(k) + CW'(1)) == cnt;

  assign stat = '{accept_last: accept && last_key,
                  i_zero:      i == '0,
                  i_le1:       i <= CW'(1),
                  sift_done:   done,
                  out_free:    free,
                  final_key:   final_key};

  always_comb begin
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    raddr_a = '0;
    raddr_b = '0;
    unique case (ctrl.op)
      OP_LOAD: begin
        we    = accept && room;
        waddr = cnt[AW-1:0];
        wdata = key_value[KW-1:0];
      end
      OP_BRD: raddr_a = i_dec[AW-1:0];
      OP_SRD: begin
        raddr_a = lc[AW-1:0];
        raddr_b = rc[AW-1:0];
      end
      OP_SCMP: begin
        we    = 1'b1;
        waddr = node;
        wdata = done ? vn : (r_ok ? rd_b : rd_a);
      end
      OP_SRD2: raddr_b = i_dec[AW-1:0];
      OP_SSWAP: begin
        we    = 1'b1;
        waddr = i_dec[AW-1:0];
        wdata = rd_a;
      end
      OP_ORD, OP_OEMIT: raddr_a = k;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      ovf        <= 1'b0;
      sort_valid <= 1'b0;
    end else begin
      if ((ctrl.op == OP_OEMIT) && free) begin
        sort_valid <= 1'b1;
      end else if (sort_ready) begin
        sort_valid <= 1'b0;
      end
      unique case (ctrl.op)
        OP_LOAD: begin
          if (accept) begin
            if (room) begin
              cnt <= cnt + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        OP_OEMIT: begin
          if (free && final_key) begin
            cnt <= '0;
            ovf <= 1'b0;
          end
        end
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_BINIT: i <= cnt >> 1;
      OP_BRD: begin
        node <= i_dec[AW-1:0];
        lim  <= cnt;
        i    <= i_dec;
      end
      OP_BLD: vn <= rd_a;
      OP_SCMP: node <= big[AW-1:0];
      OP_SINIT: i <= cnt;
      OP_SSWAP: begin
        vn   <= rd_b;
        node <= '0;
        lim  <= i_dec;
        i    <= i_dec;
      end
      OP_OINIT: k <= '0;
      OP_OEMIT: begin
        if (free) begin
          sorted_value <= 16'(rd_a);
          rank         <= 5'(k);
          end_of_run   <= final_key;
          overflowed   <= ovf;
          min_value    <= final_key ? ((k == '0) ? 16'(rd_a) : 16'(minr)) : 16'd0;
          max_value    <= final_key ? 16'(rd_a) : 16'd0;
          if (k == '0) begin
            minr <= rd_a;
          end
          if (!final_key) begin
            k <= k + AW'(1);
          end
        end
      end
      default: k <= k;
    endcase
  end

endmodule

>>> hdl/hse_checker.sv
// ----------------------------------------------------------------------------
// hse_checker
// port-level checks of the heap sorter result stream
// ----------------------------------------------------------------------------
module hse_checker (
  input logic        clk,
  input logic        rst,
  input logic        key_ready,
  input logic        sort_valid,
  input logic        sort_ready,
  input logic [15:0] sorted_value,
  input logic [4:0]  rank,
  input logic        end_of_run,
  input logic [15:0] min_value,
  input logic [15:0] max_value
);

  logic sort_take;
  assign sort_take = sort_valid && sort_ready;

  // stalled request holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    sort_valid && !sort_ready |=> sort_valid && $stable(sorted_value) && $stable(rank))
    else $error("stalled result changed");

  // no new keys while a set is still being emitted
  a_busy: assert property (@(posedge clk) disable iff (rst)
    sort_valid && !end_of_run |-> !key_ready)
    else $error("key channel open during emission");

  // ascending keys with consecutive ranks
  a_order: assert property (@(posedge clk) disable iff (rst)
    sort_take && !end_of_run |=>
      !sort_valid || (sorted_value >= $past(sorted_value)
                      && rank == $past(rank) + 5'd1))
    else $error("results out of order");

  // final request reports its own key as maximum and a minimum no larger
  a_final: assert property (@(posedge clk) disable iff (rst)
    sort_valid && end_of_run |-> max_value == sorted_value && min_value <= max_value)
    else $error("bad min or max on final result");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (.*);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// heap_sort_engine testbench
// sends sets of keys over the key channel with random gaps and random result
// stalls. a scoreboard keeps each open set, sorts it when the closing key is
// accepted, and compares every returned key, rank, end flag, min, max and
// overflow flag against it in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 32;
  localparam int ITEM_TARGET = 470;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 2000000;

  typedef enum {KEYS_SPREAD, KEYS_CLUSTERED, KEYS_EXTREME} key_mix_t;

  typedef struct {
    logic [15:0] value;
    logic [4:0]  rank;
    logic        last_of_set;
    logic [15:0] lowest;
    logic [15:0] highest;
    logic        dropped;
  } sorted_key_t;

  class sort_scoreboard;
    logic [15:0] set_keys[$];
    bit          set_dropped;
    sorted_key_t sorted_keys[$];
    int          failures;

    function void note_request(logic [15:0] key, logic closing);
      sorted_key_t item;
      int count;
      if (set_keys.size() < CAPACITY) begin
        set_keys.push_back(key);
      end else begin
        set_dropped = 1'b1;
      end
      if (closing) begin
        set_keys.sort();
        count = set_keys.size();
        for (int k = 0; k < count; k++) begin
          item.value = set_keys[k];
          item.rank = 5'(k);
          item.last_of_set = (k == count - 1);
          item.lowest = item.last_of_set ? set_keys[0] : 16'h0000;
          item.highest = item.last_of_set ? set_keys[count - 1] : 16'h0000;
          item.dropped = set_dropped;
          sorted_keys.push_back(item);
        end
        set_keys.delete();
        set_dropped = 1'b0;
      end
    endfunction

    function int pending();
      return sorted_keys.size();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(sorted_key_t got);
      sorted_key_t want;
      if (sorted_keys.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %h rank %0d",
                 $time, got.value, got.rank);
        failures++;
        return;
      end
      want = sorted_keys.pop_front();
      compare_field("sorted_value", want.value, got.value);
      compare_field("rank", 16'(want.rank), 16'(got.rank));
      compare_field("end_of_run", 16'(want.last_of_set), 16'(got.last_of_set));
      compare_field("min_value", want.lowest, got.lowest);
      compare_field("max_value", want.highest, got.highest);
      compare_field("overflowed", 16'(want.dropped), 16'(got.dropped));
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        key_valid = 1'b0;
  logic        key_ready;
  logic [15:0] key_value = 16'h0000;
  logic        last_key = 1'b0;
  logic        sort_valid;
  logic        sort_ready = 1'b0;
  logic [15:0] sorted_value;
  logic [4:0]  rank;
  logic        end_of_run;
  logic [15:0] min_value;
  logic [15:0] max_value;
  logic        overflowed;

  sort_scoreboard sort_check = new();
  bit tx_steady = 1'b1;
  bit rx_steady = 1'b1;
  int items_sent = 0;
  int cycle_count = 0;

  heap_sort_engine #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .key_valid(key_valid),
    .key_ready(key_ready),
    .key_value(key_value),
    .last_key(last_key),
    .sort_valid(sort_valid),
    .sort_ready(sort_ready),
    .sorted_value(sorted_value),
    .rank(rank),
    .end_of_run(end_of_run),
    .min_value(min_value),
    .max_value(max_value),
    .overflowed(overflowed)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, CAPACITY - 1);
    if (r < 93) return CAPACITY;
    return $urandom_range(CAPACITY + 1, CAPACITY + 8);
  endfunction

  function automatic logic [15:0] pick_key(key_mix_t mix);
    case (mix)
      KEYS_CLUSTERED: return 16'($urandom_range(0, 7));
      KEYS_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'h8000;
          default: return 16'h7FFF;
        endcase
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_key(input logic [15:0] key, input logic closing);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      key_valid <= 1'b0;
    end
    @(negedge clk);
    key_valid <= 1'b1;
    key_value <= key;
    last_key <= closing;
    @(posedge clk);
    while (!key_ready) @(posedge clk);
    sort_check.note_request(key, closing);
    items_sent++;
  endtask

  task automatic send_list(input logic [15:0] keys[$]);
    for (int i = 0; i < keys.size(); i++) begin
      send_key(keys[i], i == keys.size() - 1);
    end
  endtask

  task automatic send_set(input int len, input key_mix_t mix);
    for (int i = 0; i < len; i++) begin
      send_key(pick_key(mix), i == len - 1);
    end
  endtask

  // result side stalls
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        sort_ready <= 1'b0;
        hold--;
      end else begin
        sort_ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 2) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    sorted_key_t got;
    if (!rst && sort_valid && sort_ready) begin
      got = '{sorted_value, rank, end_of_run, min_value, max_value, overflowed};
      sort_check.check_result(got);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [15:0] batch[$];
    int len;
    int set_index;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single keys, extremes with duplicates, then descending, one-hot and repeated keys
    batch = {16'h0000};
    send_list(batch);
    batch = {16'hFFFF};
    send_list(batch);
    batch = {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001};
    send_list(batch);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    batch = {16'h0500, 16'h0400, 16'h0300, 16'h0200, 16'h0100};
    send_list(batch);
    batch = {16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h0010};
    send_list(batch);
    batch = {16'h1234, 16'h1234};
    send_list(batch);

    // full store first, then one that drops keys including the closing one, then random sets
    set_index = 0;
    while (items_sent < ITEM_TARGET) begin
      if (set_index == 0) len = CAPACITY;
      else if (set_index == 1) len = CAPACITY + 5;
      else len = pick_length();
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      send_set(len, key_mix_t'($urandom_range(0, 2)));
      set_index++;
    end
    @(negedge clk);
    key_valid <= 1'b0;

    while (sort_check.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sort_check.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
